// ----- rtl/smbpec_pkg.sv -----
// Shared types, constants and the CRC-8 step for the SMBus write frame builder.
`default_nettype none
package smbpec_pkg;

    // Largest data payload a request may carry; data_word holds at most four bytes
    localparam int MAX_DATA_BYTES = 4;
    localparam int LEN_LIMIT      = (MAX_DATA_BYTES < 4) ? MAX_DATA_BYTES : 4;

    // Request kinds
    localparam logic [1:0] KIND_REG  = 2'd0;   // register write with PEC
    localparam logic [1:0] KIND_MAC  = 2'd1;   // manufacturer block write with PEC
    localparam logic [1:0] KIND_CMD  = 2'd2;   // command without PEC
    localparam logic [1:0] KIND_NONE = 2'd3;   // unknown, produces no bytes

    // Byte constants
    localparam logic [7:0] POLY_BYTE = 8'h07;
    localparam logic [7:0] MAC_CMD   = 8'h44;
    localparam logic [7:0] TOP_BIT   = 8'h80;
    localparam logic [7:0] ZERO_BYTE = 8'h00;

    // Input transaction
    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] reg_address;
        logic [31:0] data_word;
        logic [2:0]  data_len;
    } req_t;

    // Output transaction, one per byte
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_pec;
        logic       last;
    } res_t;

    // Controller to datapath
    typedef struct packed {
        logic load;     // capture request, seed CRC with the address byte
        logic advance;  // current byte leaves, fold it into the CRC
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic req_ok;      // incoming request kind produces bytes
        logic final_byte;  // current byte is the last of the frame
    } status_t;

    // One byte of CRC-8, MSB first
    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if ((v & TOP_BIT) != ZERO_BYTE)
            begin
                v = {v[6:0], 1'b0} ^ POLY_BYTE;
            end
            else
            begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/smbpec_ctrl.sv -----
// Sequencing state machine: idle, then one byte per cycle until the frame ends.
`default_nettype none
module smbpec_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire smbpec_pkg::status_t status,
    output      smbpec_pkg::cmd_t    cmd,
    output      logic                busy,
    output      logic                strobe
);
    import smbpec_pkg::*;

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_SEND = 1'b1;

    logic [0:0] state_reg;
    logic [0:0] state_next;

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd.load    = 1'b0;
        cmd.advance = 1'b0;
        strobe      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && status.req_ok)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                strobe      = 1'b1;
                cmd.advance = 1'b1;
                if (status.final_byte)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg == ST_SEND);

endmodule
`default_nettype wire

// ----- rtl/smbpec_dp.sv -----
// Datapath: request registers, byte counter, byte select and running CRC-8.
`default_nettype none
module smbpec_dp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire smbpec_pkg::req_t    req,
    input  wire smbpec_pkg::cmd_t    cmd,
    input  wire logic                cfg_we,
    input  wire logic [6:0]          cfg_data,
    output      smbpec_pkg::status_t status,
    output      smbpec_pkg::res_t    res
);
    import smbpec_pkg::*;

    localparam logic [2:0] LIMIT = 3'(LEN_LIMIT);

    logic [6:0]  dev_addr_reg;
    logic [1:0]  kind_reg;
    logic [15:0] addr_reg;
    logic [31:0] word_reg;
    logic [2:0]  len_reg;
    logic [3:0]  idx_reg;
    logic [3:0]  last_idx_reg;
    logic [7:0]  crc_reg;

    logic [2:0]  len_sat;
    logic [3:0]  last_idx_next;
    logic [1:0]  data_sel;
    logic [7:0]  data_byte;
    logic [7:0]  frame_byte;
    logic        final_byte;
    logic        pec_byte;

    // Device address register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg <= 7'd0;
        end
        else if (cfg_we)
        begin
            dev_addr_reg <= cfg_data;
        end
    end

    // Saturated length and index of the final byte for the incoming request
    always_comb
    begin
        len_sat = (req.data_len > LIMIT) ? LIMIT : req.data_len;
        unique case (req.req_type)
            KIND_REG:  last_idx_next = {1'b0, len_sat} + 4'd1;
            KIND_MAC:  last_idx_next = {1'b0, len_sat} + 4'd4;
            KIND_CMD:  last_idx_next = 4'd2;
            default:   last_idx_next = 4'd0;
        endcase
    end

    // Request capture; payload needs no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg     <= req.req_type;
            addr_reg     <= req.reg_address;
            word_reg     <= req.data_word;
            len_reg      <= len_sat;
            last_idx_reg <= last_idx_next;
        end
    end

    // Byte counter and running CRC
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 4'd0;
            crc_reg <= ZERO_BYTE;
        end
        else if (cmd.load)
        begin
            idx_reg <= 4'd0;
            crc_reg <= crc_step(ZERO_BYTE, {dev_addr_reg, 1'b0});
        end
        else if (cmd.advance)
        begin
            idx_reg <= idx_reg + 4'd1;
            crc_reg <= crc_step(crc_reg, frame_byte);
        end
    end

    // Data byte select: data starts at index 1 for register writes, 4 for block writes
    always_comb
    begin
        data_sel = (kind_reg == KIND_REG) ? (idx_reg[1:0] - 2'd1) : idx_reg[1:0];
        unique case (data_sel)
            2'd0: data_byte = word_reg[7:0];
            2'd1: data_byte = word_reg[15:8];
            2'd2: data_byte = word_reg[23:16];
            2'd3: data_byte = word_reg[31:24];
            default: data_byte = ZERO_BYTE;
        endcase
    end

    // Frame byte for the current index
    always_comb
    begin
        final_byte = (idx_reg == last_idx_reg);
        pec_byte   = final_byte && (kind_reg != KIND_CMD);
        frame_byte = data_byte;
        priority if (pec_byte)
        begin
            frame_byte = crc_reg;
        end
        else if (kind_reg == KIND_REG)
        begin
            frame_byte = (idx_reg == 4'd0) ? addr_reg[7:0] : data_byte;
        end
        else if (kind_reg == KIND_MAC)
        begin
            unique case (idx_reg)
                4'd0:    frame_byte = MAC_CMD;
                4'd1:    frame_byte = {5'd0, len_reg} + 8'd2;
                4'd2:    frame_byte = addr_reg[7:0];
                4'd3:    frame_byte = addr_reg[15:8];
                default: frame_byte = data_byte;
            endcase
        end
        else
        begin
            unique case (idx_reg)
                4'd0:    frame_byte = MAC_CMD;
                4'd1:    frame_byte = addr_reg[7:0];
                default: frame_byte = ZERO_BYTE;
            endcase
        end
    end

    assign status.req_ok     = (req.req_type != KIND_NONE);
    assign status.final_byte = final_byte;
    assign res.out_byte      = frame_byte;
    assign res.is_pec        = pec_byte;
    assign res.last          = final_byte;

endmodule
`default_nettype wire

// ----- rtl/smbus_write_frame_pec_builder.sv -----
// Top level: SMBus write frame builder with CRC-8 packet error code.
//
//   channel   signals                      transaction taken when
//   request   start, busy, req             start && !busy
//   config    cfg_valid, cfg_ready, cfg_data   cfg_valid && cfg_ready
//   result    strobe, res                  every cycle strobe is high
//
// A request is taken at a clock edge; its first byte appears the next cycle and
// the remaining bytes follow one per cycle, 2 to 9 bytes in all, set by the
// request kind and the saturated data length. busy is high while bytes go out.
// An unknown kind is dropped without raising busy.
// Reset clears the sequencer and sets the device address to 0. The receiver
// cannot stall: each byte is valid for exactly one cycle.
`default_nettype none
module smbus_write_frame_pec_builder (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output      logic             busy,
    input  wire smbpec_pkg::req_t req,
    input  wire logic             cfg_valid,
    output      logic             cfg_ready,
    input  wire logic [6:0]       cfg_data,
    output      logic             strobe,
    output      smbpec_pkg::res_t res
);
    import smbpec_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Configuration only lands between frames
    assign cfg_ready = !busy;

    smbpec_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .strobe (strobe)
    );

    smbpec_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cmd      (cmd),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .status   (status),
        .res      (res)
    );

    // A valid request yields a byte in the very next cycle
    a_first_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.req_type != KIND_NONE) |=> strobe)
        else $error("no byte after accepted request");

    // An unknown kind never occupies the block
    a_drop_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.req_type == KIND_NONE) |=> !busy)
        else $error("unknown kind raised busy");

    // The last byte ends the frame
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && res.last) |=> !busy)
        else $error("busy after last byte");

    // The PEC is always the final byte
    a_pec_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && res.is_pec) |-> res.last)
        else $error("PEC not on last byte");

    // Bytes keep coming until the last one
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !res.last) |=> strobe)
        else $error("gap inside frame");

endmodule
`default_nettype wire
